FILE: rtl/scf_pkg.sv
package scf_pkg;

    localparam int unsigned FRAME_MAX = 13;
    localparam int unsigned LEN_W     = $clog2(FRAME_MAX + 1);

    typedef enum logic [2:0] {
        ACT_ENABLE   = 3'd0,
        ACT_VELOCITY = 3'd1,
        ACT_POSITION = 3'd2,
        ACT_STOP     = 3'd3,
        ACT_TRIGGER  = 3'd4
    } action_t;

    localparam logic [7:0]  END_BYTE     = 8'h6B;
    localparam logic [7:0]  SYNC_FLAG    = 8'h01;
    localparam logic [7:0]  ZERO_BYTE    = 8'h00;
    localparam logic [7:0]  OP_ENABLE    = 8'hF3;
    localparam logic [7:0]  ENABLE_CHECK = 8'hAB;
    localparam logic [7:0]  OP_VELOCITY  = 8'hF6;
    localparam logic [7:0]  OP_POSITION  = 8'hFD;
    localparam logic [7:0]  OP_STOP      = 8'hFE;
    localparam logic [7:0]  STOP_CHECK   = 8'h98;
    localparam logic [7:0]  OP_TRIGGER   = 8'hFF;
    localparam logic [7:0]  TRIG_CHECK   = 8'h66;
    localparam logic [15:0] MAX_RPM      = 16'd5000;

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  motor_address;
        logic        enable_flag;
        logic [7:0]  direction;
        logic [15:0] speed_rpm;
        logic [7:0]  accel_level;
        logic [31:0] pulse_count;
    } cmd_t;

    typedef struct packed {
        logic        status;
        logic [7:0]  frame_byte;
        logic        last;
        logic [31:0] frames_sent;
    } res_t;

    // Built frame handed from the builder to the serialiser.
    typedef struct packed {
        logic [FRAME_MAX-1:0][7:0] bytes;
        logic [LEN_W-1:0]          len;
        logic                      reject;
    } frame_t;

endpackage

FILE: rtl/scf_stream_if.sv
interface scf_stream_if #(
    parameter type payload_t = logic [7:0]
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/stepper_command_framer_unit.sv
// Stepper command framer. Each command word taken on cmd is checked and turned
// into its serial frame (address, opcode, big-endian fields, sync flag on
// velocity, position and stop frames, end byte 6B), which leaves on res one
// byte per word with last set on the final byte. A command that fails its
// checks gives one word with status 1, byte 0 and last 1, and does not advance
// the frame count. frames_sent carries the wrapping count of frames including
// the current one. A frame has as many words as bytes: 1 for a rejection, 4 to
// 13 for a frame, sent from the byte shift register feeding res. A command
// register in front of it lets the next command be taken while the current
// frame is going out, so frames follow back to back when res is always ready.
module stepper_command_framer_unit (
    input  logic         clk,
    input  logic         rst_n,
    scf_stream_if.sink   cmd,
    scf_stream_if.source res
);

    // Command holding register: the one stage in front of the builder.
    logic            cmd_valid_reg, cmd_valid_next;
    scf_pkg::cmd_t   cmd_reg, cmd_next;

    // Builder output and serialiser handshake.
    scf_pkg::frame_t frame;
    logic            frame_ready;
    logic            cmd_take;

    // Take a new word whenever the held one is empty or being loaded into the
    // serialiser this cycle.
    assign cmd.ready = !cmd_valid_reg || frame_ready;
    assign cmd_take  = cmd.valid && cmd.ready;

    always_comb
    begin
        cmd_valid_next = cmd_valid_reg;
        cmd_next       = cmd_reg;
        if (cmd_take)
        begin
            cmd_valid_next = 1'b1;
            cmd_next       = cmd.payload;
        end
        else if (frame_ready)
        begin
            cmd_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

    // Checks and frame layout: short logic from the command register.
    scf_frame_build u_build (
        .cmd   (cmd_reg),
        .frame (frame)
    );

    // Byte shift register, frame counter and output word.
    scf_serializer u_ser (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_valid (cmd_valid_reg),
        .frame       (frame),
        .frame_ready (frame_ready),
        .res         (res)
    );

endmodule

FILE: rtl/scf_frame_build.sv
module scf_frame_build (
    input  scf_pkg::cmd_t   cmd,
    output scf_pkg::frame_t frame
);

    logic addr_bad;
    logic motion_bad;

    assign addr_bad   = (cmd.motor_address == 8'd0);
    assign motion_bad = addr_bad || (cmd.direction > 8'd1) || (cmd.speed_rpm > scf_pkg::MAX_RPM);

    always_comb
    begin
        frame.bytes  = '0;
        frame.len    = scf_pkg::LEN_W'(1);
        frame.reject = 1'b1;
        unique case (cmd.action)
            scf_pkg::ACT_ENABLE:
            begin
                if (!addr_bad)
                begin
                    frame.bytes[0] = cmd.motor_address;
                    frame.bytes[1] = scf_pkg::OP_ENABLE;
                    frame.bytes[2] = scf_pkg::ENABLE_CHECK;
                    frame.bytes[3] = {7'd0, cmd.enable_flag};
                    frame.bytes[4] = scf_pkg::ZERO_BYTE;
                    frame.bytes[5] = scf_pkg::END_BYTE;
                    frame.len      = scf_pkg::LEN_W'(6);
                    frame.reject   = 1'b0;
                end
            end
            scf_pkg::ACT_VELOCITY:
            begin
                if (!motion_bad)
                begin
                    frame.bytes[0] = cmd.motor_address;
                    frame.bytes[1] = scf_pkg::OP_VELOCITY;
                    frame.bytes[2] = cmd.direction;
                    frame.bytes[3] = cmd.speed_rpm[15:8];
                    frame.bytes[4] = cmd.speed_rpm[7:0];
                    frame.bytes[5] = cmd.accel_level;
                    frame.bytes[6] = scf_pkg::SYNC_FLAG;
                    frame.bytes[7] = scf_pkg::END_BYTE;
                    frame.len      = scf_pkg::LEN_W'(8);
                    frame.reject   = 1'b0;
                end
            end
            scf_pkg::ACT_POSITION:
            begin
                if (!motion_bad && (cmd.pulse_count != 32'd0))
                begin
                    frame.bytes[0]  = cmd.motor_address;
                    frame.bytes[1]  = scf_pkg::OP_POSITION;
                    frame.bytes[2]  = cmd.direction;
                    frame.bytes[3]  = cmd.speed_rpm[15:8];
                    frame.bytes[4]  = cmd.speed_rpm[7:0];
                    frame.bytes[5]  = cmd.accel_level;
                    frame.bytes[6]  = cmd.pulse_count[31:24];
                    frame.bytes[7]  = cmd.pulse_count[23:16];
                    frame.bytes[8]  = cmd.pulse_count[15:8];
                    frame.bytes[9]  = cmd.pulse_count[7:0];
                    frame.bytes[10] = scf_pkg::ZERO_BYTE;
                    frame.bytes[11] = scf_pkg::SYNC_FLAG;
                    frame.bytes[12] = scf_pkg::END_BYTE;
                    frame.len       = scf_pkg::LEN_W'(13);
                    frame.reject    = 1'b0;
                end
            end
            scf_pkg::ACT_STOP:
            begin
                if (!addr_bad)
                begin
                    frame.bytes[0] = cmd.motor_address;
                    frame.bytes[1] = scf_pkg::OP_STOP;
                    frame.bytes[2] = scf_pkg::STOP_CHECK;
                    frame.bytes[3] = scf_pkg::SYNC_FLAG;
                    frame.bytes[4] = scf_pkg::END_BYTE;
                    frame.len      = scf_pkg::LEN_W'(5);
                    frame.reject   = 1'b0;
                end
            end
            scf_pkg::ACT_TRIGGER:
            begin
                // broadcast: address and fields ignored, never rejected
                frame.bytes[0] = scf_pkg::ZERO_BYTE;
                frame.bytes[1] = scf_pkg::OP_TRIGGER;
                frame.bytes[2] = scf_pkg::TRIG_CHECK;
                frame.bytes[3] = scf_pkg::END_BYTE;
                frame.len      = scf_pkg::LEN_W'(4);
                frame.reject   = 1'b0;
            end
            default:
            begin
                frame.reject = 1'b1;
            end
        endcase
    end

endmodule

FILE: rtl/scf_serializer.sv
module scf_serializer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                frame_valid,
    input  scf_pkg::frame_t     frame,
    output logic                frame_ready,
    scf_stream_if.source        res
);

    logic                                 active_reg, active_next;
    logic [scf_pkg::LEN_W-1:0]            rem_reg, rem_next;
    logic [31:0]                          total_reg, total_next;
    logic [scf_pkg::FRAME_MAX-1:0][7:0]   bytes_reg, bytes_next;
    logic                                 status_reg, status_next;
    logic [31:0]                          sent_reg, sent_next;
    logic                                 take;
    logic                                 last_byte;

    assign take        = res.valid && res.ready;
    assign last_byte   = (rem_reg == scf_pkg::LEN_W'(1));
    assign frame_ready = !active_reg || (take && last_byte);

    always_comb
    begin
        active_next = active_reg;
        rem_next    = rem_reg;
        total_next  = total_reg;
        bytes_next  = bytes_reg;
        status_next = status_reg;
        sent_next   = sent_reg;
        if (frame_ready)
        begin
            active_next = frame_valid;
            if (frame_valid)
            begin
                bytes_next  = frame.bytes;
                rem_next    = frame.len;
                status_next = frame.reject;
                if (frame.reject)
                begin
                    sent_next = total_reg;
                end
                else
                begin
                    total_next = total_reg + 32'd1;
                    sent_next  = total_reg + 32'd1;
                end
            end
        end
        else if (take)
        begin
            // drop the byte just sent
            bytes_next = bytes_reg >> 8;
            rem_next   = rem_reg - scf_pkg::LEN_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            rem_reg    <= '0;
            total_reg  <= '0;
        end
        else
        begin
            active_reg <= active_next;
            rem_reg    <= rem_next;
            total_reg  <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bytes_reg  <= bytes_next;
        status_reg <= status_next;
        sent_reg   <= sent_next;
    end

    assign res.valid               = active_reg;
    assign res.payload.status      = status_reg;
    assign res.payload.frame_byte  = bytes_reg[0];
    assign res.payload.last        = last_byte;
    assign res.payload.frames_sent = sent_reg;

endmodule
